// ===== design/assert_macros.svh =====
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bpc_pkg.sv =====
// Package with the widths, constants and types of the pressure compensation block.
package bpc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COEFF_W   = 16;
  localparam int RAW_W     = 24;
  localparam int TEMP_W    = 19;
  localparam int PRES_W    = 32;
  localparam int DT_W      = 25;
  localparam int OFF_W     = 40;
  localparam int T2_W      = 18;

  localparam int TEMP_SHIFT = 23;
  localparam int OFF_SHIFT  = 7;
  localparam int SENS_SHIFT = 8;
  localparam int T2_SHIFT   = 31;
  localparam int PROD_SHIFT = 21;
  localparam int PRES_SHIFT = 15;

  localparam logic signed [TEMP_W-1:0] TEMP_REF    = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_FRIGID = -19'sd1500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4,
    REG_TEMP_SLOPE  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_temp;
    logic [COEFF_W-1:0] offset_temp;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_slope;
  } bpc_cfg_t;

  // First-order results of one item, handed from the front to the back.
  typedef struct packed {
    logic [RAW_W-1:0]        d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sens;
    logic [T2_W-1:0]         t2;
    logic                    cold;
    logic                    frigid;
  } bpc_mid_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic signed [PRES_W-1:0] pres;
  } bpc_res_t;

  localparam int MID_W = $bits(bpc_mid_t);
  localparam int RES_W = $bits(bpc_res_t);

endpackage

// ===== design/bpc_queue.sv =====
// Small first-in first-out queue built from registers.
module bpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  // DEPTH must be a power of two, at least two; the queue itself does not enforce this.
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wr_ptr_r;
  logic [AW:0]      rd_ptr_r;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                 (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign dout  = mem_r[rd_ptr_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r[AW-1:0]] <= din;
    end
  end

endmodule

// ===== design/bpc_front.sv =====
// Front pipeline: accepts raw conversions and computes first-order terms and the cold flags.
module bpc_front import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  bpc_cfg_t         cfg,
  input  logic             in_push,
  output logic             in_full,
  input  logic [RAW_W-1:0] in_raw_pressure,
  input  logic [RAW_W-1:0] in_raw_temperature,
  input  logic             q_full,
  output logic             q_push,
  output bpc_mid_t         q_item
);

  localparam int PT_W = DT_W + COEFF_W + 1;
  localparam int SQ_W = 2 * DT_W;

  logic adv;
  logic accept;
  logic f1_v_r;
  logic f2_v_r;
  logic f3_v_r;

  logic [RAW_W-1:0]        f1_d1_r;
  logic [RAW_W-1:0]        f2_d1_r;
  logic signed [DT_W-1:0]  dt_nxt;
  logic signed [DT_W-1:0]  f1_dt_r;
  logic signed [PT_W-1:0]  pt_r;
  logic signed [PT_W-1:0]  po_r;
  logic signed [PT_W-1:0]  ps_r;
  logic signed [SQ_W-1:0]  sq_r;
  logic signed [TEMP_W-1:0] temp1;
  bpc_mid_t                item_nxt;
  bpc_mid_t                item_r;

  // All stages move together; they hold only when the last one cannot drain.
  assign adv     = !f3_v_r || !q_full;
  assign in_full = !adv;
  assign accept  = in_push && adv;
  assign q_push  = f3_v_r && !q_full;
  assign q_item  = item_r;

  assign dt_nxt = signed'({1'b0, in_raw_temperature}) - signed'({1'b0, cfg.ref_temp, 8'h00});

  always_comb begin
    temp1           = TEMP_REF + TEMP_W'(pt_r >>> TEMP_SHIFT);
    item_nxt.d1     = f2_d1_r;
    item_nxt.temp   = temp1;
    item_nxt.off    = signed'(OFF_W'({cfg.offset, 16'h0000})) + OFF_W'(po_r >>> OFF_SHIFT);
    item_nxt.sens   = signed'(OFF_W'({cfg.sens, 15'h0000})) + OFF_W'(ps_r >>> SENS_SHIFT);
    item_nxt.t2     = sq_r[T2_SHIFT+T2_W-1:T2_SHIFT];
    item_nxt.cold   = (temp1 < TEMP_REF);
    item_nxt.frigid = (temp1 < TEMP_FRIGID);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= accept;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_d1_r <= in_raw_pressure;
      f1_dt_r <= dt_nxt;
      f2_d1_r <= f1_d1_r;
      pt_r    <= f1_dt_r * signed'({1'b0, cfg.temp_slope});
      po_r    <= signed'({1'b0, cfg.offset_temp}) * f1_dt_r;
      ps_r    <= signed'({1'b0, cfg.sens_temp}) * f1_dt_r;
      sq_r    <= f1_dt_r * f1_dt_r;
      item_r  <= item_nxt;
    end
  end

endmodule

// ===== design/bpc_back.sv =====
// Back pipeline: applies the second-order correction and computes the pressure.
module bpc_back import bpc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  output logic     q_pop,
  input  bpc_mid_t q_item,
  input  logic     oq_full,
  output logic     oq_push,
  output bpc_res_t oq_item
);

  localparam int DIFF_W = TEMP_W + 1;
  localparam int FSQ_W  = 2 * DIFF_W;
  localparam int CORR_W = OFF_W + 2;
  localparam int LO_W   = OFF_W / 2;
  localparam int HI_W   = OFF_W - LO_W;
  localparam int PPLO_W = RAW_W + LO_W;
  localparam int PPHI_W = RAW_W + 1 + HI_W;
  localparam int PROD_W = 64;
  localparam int X_W    = PRES_SHIFT + PRES_W + 1;

  logic adv;
  logic b1_v_r, b2_v_r, b3_v_r, b4_v_r, b5_v_r, b6_v_r;

  logic signed [DIFF_W-1:0] tdiff;
  logic signed [DIFF_W-1:0] tfrig;
  bpc_mid_t                 b1_item_r;
  bpc_mid_t                 b2_item_r;
  logic signed [FSQ_W-1:0]  f_r;
  logic signed [FSQ_W-1:0]  f2_r;

  logic signed [CORR_W-1:0] fx;
  logic signed [CORR_W-1:0] f2x;
  logic signed [CORR_W-1:0] off2_nxt;
  logic signed [CORR_W-1:0] sens2_nxt;
  logic signed [CORR_W-1:0] off2_r;
  logic signed [CORR_W-1:0] sens2_r;

  logic signed [OFF_W-1:0]  off_nxt;
  logic signed [OFF_W-1:0]  sens_nxt;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic [RAW_W-1:0]         b3_d1_r;
  logic signed [TEMP_W-1:0] b3_temp_r;
  logic signed [OFF_W-1:0]  b3_off_r;
  logic signed [OFF_W-1:0]  b3_sens_r;

  logic signed [TEMP_W-1:0] b4_temp_r;
  logic signed [OFF_W-1:0]  b4_off_r;
  logic [PPLO_W-1:0]        pplo_r;
  logic signed [PPHI_W-1:0] pphi_r;

  logic signed [TEMP_W-1:0] b5_temp_r;
  logic signed [OFF_W-1:0]  b5_off_r;
  logic signed [PROD_W-1:0] prod_r;

  logic signed [X_W-1:0]    x_nxt;
  bpc_res_t                 res_nxt;
  bpc_res_t                 res_r;

  assign adv     = !b6_v_r || !oq_full;
  assign q_pop   = adv && !q_empty;
  assign oq_push = b6_v_r && !oq_full;
  assign oq_item = res_r;

  assign tdiff = DIFF_W'(q_item.temp) - DIFF_W'(TEMP_REF);
  assign tfrig = DIFF_W'(q_item.temp) - DIFF_W'(TEMP_FRIGID);

  // The squares are nonnegative whenever they are used, so plain shifts and adds
  // give the small constant multiples.
  always_comb begin
    fx        = CORR_W'(f_r);
    f2x       = CORR_W'(f2_r);
    off2_nxt  = ((fx <<< 2) + fx) >>> 1;
    sens2_nxt = ((fx <<< 2) + fx) >>> 2;
    if (b1_item_r.frigid) begin
      off2_nxt  = off2_nxt + (f2x <<< 3) - f2x;
      sens2_nxt = sens2_nxt + (((f2x <<< 3) + (f2x <<< 1) + f2x) >>> 1);
    end
  end

  always_comb begin
    off_nxt  = b2_item_r.off;
    sens_nxt = b2_item_r.sens;
    temp_nxt = b2_item_r.temp;
    if (b2_item_r.cold) begin
      off_nxt  = b2_item_r.off - OFF_W'(off2_r);
      sens_nxt = b2_item_r.sens - OFF_W'(sens2_r);
      temp_nxt = b2_item_r.temp - signed'({1'b0, b2_item_r.t2});
    end
  end

  always_comb begin
    x_nxt        = X_W'(prod_r >>> PROD_SHIFT) - X_W'(b5_off_r);
    res_nxt.temp = b5_temp_r;
    res_nxt.pres = x_nxt[PRES_SHIFT+PRES_W-1:PRES_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
      b2_v_r <= 1'b0;
      b3_v_r <= 1'b0;
      b4_v_r <= 1'b0;
      b5_v_r <= 1'b0;
      b6_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r <= q_pop;
      b2_v_r <= b1_v_r;
      b3_v_r <= b2_v_r;
      b4_v_r <= b3_v_r;
      b5_v_r <= b4_v_r;
      b6_v_r <= b5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_item_r <= q_item;
      f_r       <= tdiff * tdiff;
      f2_r      <= tfrig * tfrig;

      b2_item_r <= b1_item_r;
      off2_r    <= off2_nxt;
      sens2_r   <= sens2_nxt;

      b3_d1_r   <= b2_item_r.d1;
      b3_temp_r <= temp_nxt;
      b3_off_r  <= off_nxt;
      b3_sens_r <= sens_nxt;

      // The wide product is split into two partial products on the halves of sens.
      b4_temp_r <= b3_temp_r;
      b4_off_r  <= b3_off_r;
      pplo_r    <= b3_d1_r * b3_sens_r[LO_W-1:0];
      pphi_r    <= signed'({1'b0, b3_d1_r}) * signed'(b3_sens_r[OFF_W-1:LO_W]);

      b5_temp_r <= b4_temp_r;
      b5_off_r  <= b4_off_r;
      prod_r    <= (PROD_W'(pphi_r) <<< LO_W) + signed'(PROD_W'(pplo_r));

      res_r     <= res_nxt;
    end
  end

endmodule

// ===== design/barometric_pressure_compensation.sv =====
// Top level of the barometric pressure compensation block.
// Each item is one pair of raw 24-bit conversions; the block returns the compensated
// temperature in hundredths of a degree and the pressure in pascals (low 32 bits),
// with the second-order correction below 20.00 degrees and the extra term below
// -15.00 degrees. It is fully pipelined and takes one item every cycle while in_full
// is low; an item passes through the three front stages, the queue between front and
// back, the six back stages that hold the registered multipliers and the split
// pressure product, and the output queue. The six calibration words must be written
// through the cfg port while the block is idle; the block does not enforce this.
// cfg_ready is always high and writes to indexes beyond the list are ignored.
module barometric_pressure_compensation import bpc_pkg::*; #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic signed [TEMP_W-1:0] out_temperature_centi,
  output logic signed [PRES_W-1:0] out_pressure,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [COEFF_W-1:0]       cfg_data
);

  bpc_cfg_t   cfg_r;
  logic       mid_push;
  logic       mid_full;
  logic       mid_pop;
  logic       mid_empty;
  bpc_mid_t   mid_in_item;
  bpc_mid_t   mid_out_item;
  logic [MID_W-1:0] mid_din;
  logic [MID_W-1:0] mid_dout;
  logic       res_push;
  logic       res_full;
  bpc_res_t   res_item;
  bpc_res_t   out_item;
  logic [RES_W-1:0] res_din;
  logic [RES_W-1:0] res_dout;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SENS:        cfg_r.sens        <= cfg_data;
        REG_OFFSET:      cfg_r.offset      <= cfg_data;
        REG_SENS_TEMP:   cfg_r.sens_temp   <= cfg_data;
        REG_OFFSET_TEMP: cfg_r.offset_temp <= cfg_data;
        REG_REF_TEMP:    cfg_r.ref_temp    <= cfg_data;
        REG_TEMP_SLOPE:  cfg_r.temp_slope  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bpc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .q_full             (mid_full),
    .q_push             (mid_push),
    .q_item             (mid_in_item)
  );

  assign mid_din      = mid_in_item;
  assign mid_out_item = mid_dout;

  bpc_queue #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_din),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  bpc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (mid_empty),
    .q_pop   (mid_pop),
    .q_item  (mid_out_item),
    .oq_full (res_full),
    .oq_push (res_push),
    .oq_item (res_item)
  );

  assign res_din  = res_item;
  assign out_item = res_dout;

  bpc_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_din),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_dout),
    .empty (out_empty)
  );

  assign out_temperature_centi = out_item.temp;
  assign out_pressure          = out_item.pres;

endmodule

// ===== design/bpc_checker.sv =====
// Port-level checker for the pressure compensation block and its bind.
`include "assert_macros.svh"

module bpc_checker import bpc_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input logic signed [TEMP_W-1:0] out_temperature_centi,
  input logic signed [PRES_W-1:0] out_pressure
);

  // Right after reset nothing is pending and the input side is open.
  `BPC_ASSERT_IMPL(a_reset_clean, clk, rst_n, $past(!rst_n), out_empty && !in_full, "not clean after reset")

  // No item can cross both pipelines before the minimum latency after a reset has passed.
  `BPC_ASSERT_IMPL(a_min_latency, clk, rst_n, $past(!rst_n, 8), out_empty, "result too early")

  // A result that is not taken stays in place.
  `BPC_ASSERT_NEXT(a_result_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_temperature_centi) && $stable(out_pressure), "result changed")

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_full               (in_full),
  .out_empty             (out_empty),
  .out_pop               (out_pop),
  .out_temperature_centi (out_temperature_centi),
  .out_pressure          (out_pressure)
);

// ===== tb/tb_top.sv =====
// Testbench for the barometric pressure compensation block: calibration, stimulus and checking.
module tb_top import bpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_COEFFS = 6;
  localparam logic [RAW_W-1:0] RAW_MAX = '1;
  localparam logic [COEFF_W-1:0] COEFF_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [RAW_W-1:0] in_raw_pressure = '0;
  logic [RAW_W-1:0] in_raw_temperature = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic signed [PRES_W-1:0] out_pressure;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0] cfg_data = '0;

  // Calibration words as the block should hold them; all zero after reset.
  bpc_cfg_t coeffs = '0;
  bpc_res_t expected_readings[$];
  int mismatch_count = 0;
  // Clears both sides' random idling for a stretch of full-rate traffic.
  bit idle_on = 1'b1;

  barometric_pressure_compensation u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_push               (in_push),
    .in_full               (in_full),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_empty             (out_empty),
    .out_pop               (out_pop),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure          (out_pressure),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // First-order compensation, then the second-order terms below 20.00 degrees and
  // the extra terms below -15.00 degrees. All arithmetic is 64-bit signed.
  function automatic bpc_res_t compensate(input logic [RAW_W-1:0] d1,
                                          input logic [RAW_W-1:0] d2);
    longint dt, temp, off, sens, t2, f, f2, off2, sens2, pres;
    bpc_res_t res;
    dt = longint'(d2) - (longint'(coeffs.ref_temp) << 8);
    temp = longint'(TEMP_REF) + ((dt * longint'(coeffs.temp_slope)) >>> TEMP_SHIFT);
    off = (longint'(coeffs.offset) << 16) + ((longint'(coeffs.offset_temp) * dt) >>> OFF_SHIFT);
    sens = (longint'(coeffs.sens) << 15) + ((longint'(coeffs.sens_temp) * dt) >>> SENS_SHIFT);
    if (temp < longint'(TEMP_REF)) begin
      t2 = (dt * dt) >>> T2_SHIFT;
      f = (temp - longint'(TEMP_REF)) * (temp - longint'(TEMP_REF));
      off2 = (5 * f) >>> 1;
      sens2 = (5 * f) >>> 2;
      if (temp < longint'(TEMP_FRIGID)) begin
        f2 = (temp - longint'(TEMP_FRIGID)) * (temp - longint'(TEMP_FRIGID));
        off2 += 7 * f2;
        sens2 += (11 * f2) >>> 1;
      end
      temp -= t2;
      off -= off2;
      sens -= sens2;
    end
    pres = (((longint'(d1) * sens) >>> PROD_SHIFT) - off) >>> PRES_SHIFT;
    res.temp = temp[TEMP_W-1:0];
    res.pres = pres[PRES_W-1:0];
    return res;
  endfunction

  // Result side: random pop, each accepted result checked against the oldest prediction.
  always @(posedge clk) begin
    bpc_res_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_readings.size() == 0) begin
        $error("result with no item pending: temperature_centi %0d pressure %0d",
               out_temperature_centi, out_pressure);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        if (out_temperature_centi !== want.temp) begin
          $error("temperature_centi: expected %0d, actual %0d", want.temp,
                 out_temperature_centi);
          mismatch_count++;
        end
        if (out_pressure !== want.pres) begin
          $error("pressure: expected %0d, actual %0d", want.pres, out_pressure);
          mismatch_count++;
        end
      end
    end
    out_pop <= !(idle_on && $urandom_range(99) < 7);
  end

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_coeff(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SENS:        coeffs.sens = val;
      REG_OFFSET:      coeffs.offset = val;
      REG_SENS_TEMP:   coeffs.sens_temp = val;
      REG_OFFSET_TEMP: coeffs.offset_temp = val;
      REG_REF_TEMP:    coeffs.ref_temp = val;
      REG_TEMP_SLOPE:  coeffs.temp_slope = val;
      default: ;
    endcase
  endtask

  task automatic load_calibration(input bpc_cfg_t c);
    write_coeff(REG_SENS, c.sens);
    write_coeff(REG_OFFSET, c.offset);
    write_coeff(REG_SENS_TEMP, c.sens_temp);
    write_coeff(REG_OFFSET_TEMP, c.offset_temp);
    write_coeff(REG_REF_TEMP, c.ref_temp);
    write_coeff(REG_TEMP_SLOPE, c.temp_slope);
    cfg_valid <= 1'b0;
  endtask

  // Leaves in_push high after acceptance; the next item or a drain decides its value.
  // A random pause before 4 percent of the items keeps idling near 7 percent.
  task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    if (idle_on && $urandom_range(99) < 4) begin
      in_push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_raw_pressure <= d1;
    in_raw_temperature <= d2;
    do @(posedge clk); while (in_full);
    expected_readings.push_back(compensate(d1, d2));
  endtask

  // Half of the temperatures land near the reference point, where the bands change.
  task automatic send_random_pair();
    logic [RAW_W-1:0] d1, d2;
    int near;
    case ($urandom_range(9))
      0: d1 = '0;
      1: d1 = RAW_MAX;
      default: d1 = RAW_W'($urandom);
    endcase
    if ($urandom_range(1)) begin
      d2 = RAW_W'($urandom);
    end else begin
      near = (int'(coeffs.ref_temp) << 8) + int'($urandom_range(1 << 22)) - (1 << 21);
      if (near < 0) near = 0;
      if (near > int'(RAW_MAX)) near = int'(RAW_MAX);
      d2 = RAW_W'(near);
    end
    send_pair(d1, d2);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic test_reset_calibration();
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    drain_results();
  endtask

  task automatic test_extreme_calibration();
    load_calibration('1);
    send_pair('0, '0);
    send_pair(RAW_MAX, RAW_MAX);
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    drain_results();
  endtask

  // With both reference and slope at half scale, the first-order temperature is
  // 2000 + dt/256, so each band edge sits on an exact raw value.
  task automatic test_temperature_bands();
    bpc_cfg_t c;
    logic [RAW_W-1:0] ref_raw;
    c = '{sens: 16'd40127, offset: 16'd36924, sens_temp: 16'd23317,
          offset_temp: 16'd23282, ref_temp: 16'h8000, temp_slope: 16'h8000};
    load_calibration(c);
    ref_raw = RAW_W'(c.ref_temp) << 8;
    send_pair(24'd8000000, ref_raw);
    send_pair(24'd8000000, ref_raw - 24'd1);
    send_pair(RAW_MAX, ref_raw - 24'd896000);
    send_pair(RAW_MAX, ref_raw - 24'd896001);
    send_pair(RAW_MAX, '0);
    send_pair(24'd8000000, RAW_MAX);
    drain_results();
  endtask

  // Writes past the last register must leave the calibration untouched.
  task automatic test_ignored_index();
    for (int i = NUM_COEFFS; i < 2 ** CFG_IDX_W; i++) write_coeff(CFG_IDX_W'(i), COEFF_MAX);
    cfg_valid <= 1'b0;
    send_pair(RAW_MAX, '0);
    send_pair('0, RAW_MAX);
    send_random_pair();
    drain_results();
  endtask

  task automatic test_random_calibrations();
    bpc_cfg_t plan[$];
    plan.push_back('0);
    plan.push_back('1);
    plan.push_back('{sens: 16'd40127, offset: 16'd36924, sens_temp: 16'd23317,
                     offset_temp: 16'd23282, ref_temp: 16'd33464, temp_slope: 16'd28312});
    repeat (4) plan.push_back(bpc_cfg_t'({$urandom, $urandom, $urandom}));
    foreach (plan[i]) begin
      load_calibration(plan[i]);
      repeat (90) send_random_pair();
      drain_results();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    load_calibration(bpc_cfg_t'({$urandom, $urandom, $urandom}));
    repeat (100) send_random_pair();
    drain_results();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_calibration();
    test_extreme_calibration();
    test_temperature_bands();
    test_ignored_index();
    test_random_calibrations();
    test_full_rate();
    // Any stray result would show up within the pipeline latency.
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
